/* hdl/smhc_pkg.sv */
package smhc_pkg;

	// widths of the item fields and of the internal state
	localparam int POS_W     = 20;
	localparam int PHASE_W   = 16;
	localparam int CNT_W     = 19;
	localparam int TQ4_W     = 14;
	localparam int LOWT_W    = 16;
	localparam int SPM_W     = 16;
	localparam int TRAVEL_W  = 10;
	localparam int BACKOFF_W = 8;
	localparam int PHIGH_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// derived widths
	localparam int TGT_W     = TQ4_W + SPM_W - 12;
	localparam int LIMIT_W   = TRAVEL_W + SPM_W - 8;
	localparam int BOSTEP_W  = BACKOFF_W + SPM_W - 8;
	localparam int DELTA_W   = (POS_W > TGT_W ? POS_W : TGT_W) + 2;
	localparam int CMP_W     = (POS_W > LIMIT_W ? POS_W : LIMIT_W);

	localparam logic [CNT_W-1:0] STEPS_MAX = '1;

	// register reset values
	localparam logic [SPM_W-1:0]     SPM_RST     = 16'd25600;
	localparam logic [TRAVEL_W-1:0]  TRAVEL_RST  = 10'd100;
	localparam logic [BACKOFF_W-1:0] BACKOFF_RST = 8'd30;
	localparam logic [PHIGH_W-1:0]   PHIGH_RST   = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEPS_PER_MM = 2'd0,
		CFG_MAX_TRAVEL   = 2'd1,
		CFG_BACKOFF      = 2'd2,
		CFG_PULSE_HIGH   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_REL  = 2'd1,
		REQ_ABS  = 2'd2,
		REQ_HOME = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_MOVE = 3'b010,
		MODE_HOME = 3'b100
	} mode_t;

	typedef struct packed {
		logic [SPM_W-1:0]    spm;
		logic [TRAVEL_W-1:0] travel;
		logic [PHIGH_W-1:0]  pulse_high;
		logic [LIMIT_W-1:0]  limit;
		logic [BOSTEP_W-1:0] backoff_steps;
	} cfg_t;

	// item after the input stage: target already scaled to steps
	typedef struct packed {
		req_t               req;
		logic [CNT_W-1:0]   cnt;
		logic               fwd;
		logic [TGT_W-1:0]   tgt;
		logic [PHASE_W-1:0] low;
		logic               endstop;
		logic               abort_req;
	} item_t;

	typedef struct packed {
		logic             step;
		logic             dir;
		logic [POS_W-1:0] pos;
		logic             busy;
		logic             homing_ok;
		logic             finished;
		logic             rejected;
	} result_t;

endpackage

/* hdl/smhc_cfg.sv */
module smhc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [smhc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smhc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output smhc_pkg::cfg_t                   cfg
);

	logic [smhc_pkg::SPM_W-1:0]     spm_q;
	logic [smhc_pkg::TRAVEL_W-1:0]  travel_q;
	logic [smhc_pkg::BACKOFF_W-1:0] backoff_q;
	logic [smhc_pkg::PHIGH_W-1:0]   phigh_q;
	logic [smhc_pkg::LIMIT_W-1:0]   limit_q;
	logic [smhc_pkg::BOSTEP_W-1:0]  bosteps_q;
	logic [smhc_pkg::TRAVEL_W+smhc_pkg::SPM_W-1:0]  limit_prod;
	logic [smhc_pkg::BACKOFF_W+smhc_pkg::SPM_W-1:0] bo_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q     <= smhc_pkg::SPM_RST;
			travel_q  <= smhc_pkg::TRAVEL_RST;
			backoff_q <= smhc_pkg::BACKOFF_RST;
			phigh_q   <= smhc_pkg::PHIGH_RST;
		end else if (cfg_valid) begin
			unique case (smhc_pkg::cfg_idx_t'(cfg_index))
				smhc_pkg::CFG_STEPS_PER_MM: spm_q <= smhc_pkg::SPM_W'(cfg_data);
				smhc_pkg::CFG_MAX_TRAVEL:   travel_q <= smhc_pkg::TRAVEL_W'(cfg_data);
				smhc_pkg::CFG_BACKOFF:      backoff_q <= smhc_pkg::BACKOFF_W'(cfg_data);
				smhc_pkg::CFG_PULSE_HIGH:   phigh_q <= smhc_pkg::PHIGH_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// travel limit and backoff in steps, registered in the cycle after the writes
	assign limit_prod = (smhc_pkg::TRAVEL_W+smhc_pkg::SPM_W)'(travel_q) *
		(smhc_pkg::TRAVEL_W+smhc_pkg::SPM_W)'(spm_q);
	assign bo_prod = (smhc_pkg::BACKOFF_W+smhc_pkg::SPM_W)'(backoff_q) *
		(smhc_pkg::BACKOFF_W+smhc_pkg::SPM_W)'(spm_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= '0;
			bosteps_q <= '0;
		end else begin
			limit_q   <= limit_prod[smhc_pkg::TRAVEL_W+smhc_pkg::SPM_W-1:8];
			bosteps_q <= bo_prod[smhc_pkg::BACKOFF_W+smhc_pkg::SPM_W-1:8];
		end
	end

	assign cfg.spm           = spm_q;
	assign cfg.travel        = travel_q;
	assign cfg.pulse_high    = phigh_q;
	assign cfg.limit         = limit_q;
	assign cfg.backoff_steps = bosteps_q;

endmodule

/* hdl/smhc_in_stage.sv */
module smhc_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  smhc_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [smhc_pkg::CNT_W-1:0]     step_count,
	input  logic                           move_forward,
	input  logic [smhc_pkg::TQ4_W-1:0]     target_mm_q4,
	input  logic [smhc_pkg::LOWT_W-1:0]    low_ticks,
	input  logic                           endstop_pressed,
	input  logic                           monitor_abort,
	input  logic                           core_ready,
	output logic                           valid_s1,
	output smhc_pkg::item_t                item_s1
);

	localparam int PROD_W = smhc_pkg::TQ4_W + smhc_pkg::SPM_W;

	logic [smhc_pkg::TQ4_W-1:0] lim_q4;
	logic [smhc_pkg::TQ4_W-1:0] tq4_clamped;
	logic [PROD_W-1:0]          prod;
	logic [PROD_W-1:0]          prod_rnd;
	logic                       load;

	// clamp to 16 * travel, scale by Q8.8 steps/mm, round half up
	assign lim_q4      = smhc_pkg::TQ4_W'({cfg.travel, 4'b0000});
	assign tq4_clamped = (target_mm_q4 > lim_q4) ? lim_q4 : target_mm_q4;
	assign prod        = PROD_W'(tq4_clamped) * PROD_W'(cfg.spm);
	assign prod_rnd    = prod + PROD_W'(2048);

	assign load     = !valid_s1 || core_ready;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1.req       <= smhc_pkg::req_t'(req_type);
			item_s1.cnt       <= step_count;
			item_s1.fwd       <= move_forward;
			item_s1.tgt       <= prod_rnd[PROD_W-1:12];
			item_s1.low       <= smhc_pkg::PHASE_W'(low_ticks);
			item_s1.endstop   <= endstop_pressed;
			item_s1.abort_req <= monitor_abort;
		end
	end

endmodule

/* hdl/smhc_core.sv */
module smhc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  smhc_pkg::cfg_t    cfg,
	input  logic              valid_s1,
	input  smhc_pkg::item_t   item_s1,
	output logic              core_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output smhc_pkg::result_t res_q
);

	localparam int POS_W   = smhc_pkg::POS_W;
	localparam int PHASE_W = smhc_pkg::PHASE_W;
	localparam int CNT_W   = smhc_pkg::CNT_W;
	localparam int DELTA_W = smhc_pkg::DELTA_W;
	localparam int CMP_W   = smhc_pkg::CMP_W;

	smhc_pkg::mode_t    mode_q, mode_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [CNT_W-1:0]   left_q, left_n;
	logic               fwd_q, fwd_n;
	logic               high_q, high_n;
	logic [PHASE_W-1:0] pc_q, pc_n;
	logic [PHASE_W-1:0] low_q, low_n;
	logic               hok_q, hok_n;
	logic               out_valid_q;

	logic               step, fin, rej;
	logic               take;
	logic [POS_W-1:0]   abs_pos;
	logic               over_limit;
	logic               bp_high;
	logic [PHASE_W-1:0] bp_pc;
	logic [PHASE_W-1:0] pc_dec;
	logic signed [DELTA_W-1:0] delta;
	logic [DELTA_W-1:0] mag;
	logic [CNT_W-1:0]   abs_steps;
	smhc_pkg::result_t  res;

	assign take       = valid_s1 && (!out_valid_q || !out_stall);
	assign core_ready = !out_valid_q || !out_stall;

	// travel check on |position|
	assign abs_pos    = pos_q[POS_W-1] ? (POS_W'(0) - pos_q) : pos_q;
	assign over_limit = CMP_W'(abs_pos) > CMP_W'(cfg.limit);

	// step start: high phase if more than one high tick, else straight to low
	assign bp_high = cfg.pulse_high > 8'd1;
	assign bp_pc   = bp_high ? PHASE_W'(cfg.pulse_high - 8'd1) : low_q;
	assign pc_dec  = pc_q - PHASE_W'(1);

	// absolute move distance
	assign delta = $signed(DELTA_W'(item_s1.tgt)) - DELTA_W'($signed(pos_q));
	assign mag   = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
	assign abs_steps = (mag > DELTA_W'(smhc_pkg::STEPS_MAX)) ? smhc_pkg::STEPS_MAX :
		CNT_W'(mag);

	always_comb begin
		mode_n = mode_q;
		pos_n  = pos_q;
		left_n = left_q;
		fwd_n  = fwd_q;
		high_n = high_q;
		pc_n   = pc_q;
		low_n  = low_q;
		hok_n  = hok_q;
		step   = 1'b0;
		fin    = 1'b0;
		rej    = 1'b0;
		if (item_s1.req != smhc_pkg::REQ_TICK) begin
			if (mode_q != smhc_pkg::MODE_IDLE) begin
				rej = 1'b1;
			end else begin
				low_n  = item_s1.low;
				high_n = 1'b0;
				pc_n   = '0;
				unique case (item_s1.req)
					smhc_pkg::REQ_REL: begin
						mode_n = smhc_pkg::MODE_MOVE;
						fwd_n  = item_s1.fwd;
						left_n = item_s1.cnt;
					end
					smhc_pkg::REQ_ABS: begin
						mode_n = smhc_pkg::MODE_MOVE;
						fwd_n  = !delta[DELTA_W-1] && (delta != '0);
						left_n = abs_steps;
					end
					smhc_pkg::REQ_HOME: begin
						mode_n = smhc_pkg::MODE_HOME;
						fwd_n  = 1'b0;
						left_n = item_s1.cnt;
					end
					default: ;
				endcase
			end
		end else if (mode_q != smhc_pkg::MODE_IDLE) begin
			if (high_q) begin
				step = 1'b1;
				if (pc_dec == '0) begin
					high_n = 1'b0;
					pc_n   = low_q;
				end else begin
					pc_n = pc_dec;
				end
			end else if (pc_q != '0) begin
				pc_n = pc_dec;
			end else begin
				unique case (mode_q)
					smhc_pkg::MODE_MOVE: begin
						if (left_q == '0 || over_limit || (!fwd_q && item_s1.endstop)) begin
							mode_n = smhc_pkg::MODE_IDLE;
							fin    = 1'b1;
						end else begin
							left_n = left_q - CNT_W'(1);
							pos_n  = fwd_q ? pos_q + POS_W'(1) : pos_q - POS_W'(1);
							step   = 1'b1;
							high_n = bp_high;
							pc_n   = bp_pc;
						end
					end
					smhc_pkg::MODE_HOME: begin
						if (left_q == '0) begin
							hok_n  = 1'b0;
							mode_n = smhc_pkg::MODE_IDLE;
							fin    = 1'b1;
						end else if (item_s1.endstop) begin
							// found: zero here, then back off forward from zero
							hok_n = 1'b1;
							fwd_n = 1'b1;
							pos_n = '0;
							if (cfg.backoff_steps == '0) begin
								mode_n = smhc_pkg::MODE_IDLE;
								left_n = '0;
								fin    = 1'b1;
							end else begin
								mode_n = smhc_pkg::MODE_MOVE;
								left_n = CNT_W'(cfg.backoff_steps) - CNT_W'(1);
								pos_n  = POS_W'(1);
								step   = 1'b1;
								high_n = bp_high;
								pc_n   = bp_pc;
							end
						end else if (item_s1.abort_req) begin
							hok_n  = 1'b0;
							mode_n = smhc_pkg::MODE_IDLE;
							fin    = 1'b1;
						end else begin
							left_n = left_q - CNT_W'(1);
							step   = 1'b1;
							high_n = bp_high;
							pc_n   = bp_pc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		res.step      = step;
		res.dir       = fwd_n;
		res.pos       = pos_n;
		res.busy      = mode_n != smhc_pkg::MODE_IDLE;
		res.homing_ok = hok_n;
		res.finished  = fin;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= smhc_pkg::MODE_IDLE;
			pos_q  <= '0;
			left_q <= '0;
			fwd_q  <= 1'b0;
			high_q <= 1'b0;
			pc_q   <= '0;
			low_q  <= '0;
			hok_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			left_q <= left_n;
			fwd_q  <= fwd_n;
			high_q <= high_n;
			pc_q   <= pc_n;
			low_q  <= low_n;
			hok_q  <= hok_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/stepper_move_and_home_controller.sv */
// Step/direction pulse generator with relative moves, absolute moves and
// homing. Every input item gives exactly one result item. The block takes one
// item per clock when the result side does not stall. An item passes through
// the input register and then the result register before it reaches the
// result outputs. The position/phase state update is combinational next-state
// logic around a single set of state registers in
// the core, which sets the one-item-per-clock figure; the absolute target
// (clamp, Q8.8 scale, round) is worked out ahead of the input register. Each
// tick item (req_type 0) is one unit of pulse timing: step_out is high on the
// decision tick that starts a step and on the next pulse_high_ticks-1 ticks,
// then low for low_ticks ticks (low_ticks is latched by the command). Commands
// that arrive while a move or homing is running come back with cmd_rejected
// set and change nothing. Configuration writes are always taken (cfg_ready is
// tied high) and must be done while the block is idle; the travel limit and
// backoff distance in steps are registered from the config registers in the
// cycle after a write.
module stepper_move_and_home_controller (
	input  logic                                clk,
	input  logic                                arst_n,

	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smhc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smhc_pkg::CFG_DATA_W-1:0]     cfg_data,

	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic [smhc_pkg::CNT_W-1:0]          step_count,
	input  logic                                move_forward,
	input  logic [smhc_pkg::TQ4_W-1:0]          target_mm_q4,
	input  logic [smhc_pkg::LOWT_W-1:0]         low_ticks,
	input  logic                                endstop_pressed,
	input  logic                                monitor_abort,

	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                step_out,
	output logic                                dir_out,
	output logic signed [smhc_pkg::POS_W-1:0]   position_steps,
	output logic                                busy_res,
	output logic                                homing_ok,
	output logic                                finished,
	output logic                                cmd_rejected
);

	smhc_pkg::cfg_t    cfg;
	smhc_pkg::item_t   item_s1;
	smhc_pkg::result_t res_q;
	logic              valid_s1;
	logic              core_ready;

	assign cfg_ready = 1'b1;

	// config registers plus derived step counts
	smhc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register; absolute target is scaled to steps on the way in
	smhc_in_stage u_in (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.step_count      (step_count),
		.move_forward    (move_forward),
		.target_mm_q4    (target_mm_q4),
		.low_ticks       (low_ticks),
		.endstop_pressed (endstop_pressed),
		.monitor_abort   (monitor_abort),
		.core_ready      (core_ready),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	// mode / position / pulse timing state and the result register
	smhc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.core_ready (core_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.res_q      (res_q)
	);

	assign step_out       = res_q.step;
	assign dir_out        = res_q.dir;
	assign position_steps = $signed(res_q.pos);
	assign busy_res       = res_q.busy;
	assign homing_ok      = res_q.homing_ok;
	assign finished       = res_q.finished;
	assign cmd_rejected   = res_q.rejected;

`ifndef SYNTHESIS
	// an ending item never also reports a rejected command
	a_fin_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(finished && cmd_rejected))
		else $error("finished and cmd_rejected on the same result");

	// a step pulse only happens while an operation is still running
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && step_out) |-> busy_res)
		else $error("step_out high with busy_res low");

	// an operation that ends leaves the block idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && finished) |-> !busy_res)
		else $error("finished with busy_res still high");

	// a rejected command result never carries a step
	a_cmd_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cmd_rejected) |-> !step_out)
		else $error("rejected command produced a step");
`endif

endmodule

/* dv/tb_stepper_move_and_home_controller.sv */
`timescale 1ns / 100ps

module tb_stepper_move_and_home_controller;
	import smhc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int QUIET_CYCLES = 8;     // quiet margin after the last owed result has come back
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the back-pressure test
	localparam int RANDOM_ITEMS = 120;
	localparam int RANDOM_PHASES = 6;

	// one request as the sender sees it
	typedef struct {
		req_t                req;
		logic [CNT_W-1:0]    cnt;
		logic                fwd;
		logic [TQ4_W-1:0]    tq4;
		logic [LOWT_W-1:0]   low;
		logic                endstop;
		logic                abort_req;
	} motor_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            req_type = '0;
	logic [CNT_W-1:0]      step_count = '0;
	logic                  move_forward = 1'b0;
	logic [TQ4_W-1:0]      target_mm_q4 = '0;
	logic [LOWT_W-1:0]     low_ticks = '0;
	logic                  endstop_pressed = 1'b0;
	logic                  monitor_abort = 1'b0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  step_out;
	logic                  dir_out;
	logic signed [POS_W-1:0] position_steps;
	logic                  busy_res;
	logic                  homing_ok;
	logic                  finished;
	logic                  cmd_rejected;

	stepper_move_and_home_controller uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.step_count      (step_count),
		.move_forward    (move_forward),
		.target_mm_q4    (target_mm_q4),
		.low_ticks       (low_ticks),
		.endstop_pressed (endstop_pressed),
		.monitor_abort   (monitor_abort),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.step_out        (step_out),
		.dir_out         (dir_out),
		.position_steps  (position_steps),
		.busy_res        (busy_res),
		.homing_ok       (homing_ok),
		.finished        (finished),
		.cmd_rejected    (cmd_rejected)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Motor state mirror: registers and controller state, reset values
	// ------------------------------------------------------------------
	logic [SPM_W-1:0]     spm_q8       = SPM_RST;
	logic [TRAVEL_W-1:0]  travel_mm    = TRAVEL_RST;
	logic [BACKOFF_W-1:0] backoff_mm_r = BACKOFF_RST;
	logic [PHIGH_W-1:0]   high_ticks   = PHIGH_RST;

	mode_t               motor_mode     = MODE_IDLE;
	logic [POS_W-1:0]    motor_pos      = '0;
	logic [CNT_W-1:0]    steps_to_go    = '0;
	logic                going_fwd      = 1'b0;
	logic                pulse_high_now = 1'b0;
	logic [PHASE_W-1:0]  phase_ticks    = '0;
	logic [PHASE_W-1:0]  low_hold       = '0;
	logic                homed_flag     = 1'b0;

	result_t motor_reports_due[$];   // results owed by the block, oldest first

	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	result_t want;

	// step begins: high phase for pulse_high-1 more ticks, or straight to low phase
	function automatic void start_pulse();
		logic [PHIGH_W-1:0] hi;
		hi = (high_ticks == 0) ? PHIGH_W'(1) : high_ticks;
		if (hi > 1) begin
			pulse_high_now = 1'b1;
			phase_ticks = PHASE_W'(hi - 1'b1);
		end else begin
			pulse_high_now = 1'b0;
			phase_ticks = low_hold;
		end
	endfunction

	// decision tick of a move: steps done, travel limit, endstop when going back
	function automatic bit move_step(input bit es, output bit fin);
		int lim;
		int p;
		int ap;
		fin = 1'b0;
		lim = (int'(travel_mm) * int'(spm_q8)) >>> 8;
		p = int'($signed(motor_pos));
		ap = (p < 0) ? -p : p;
		if (steps_to_go == 0 || ap > lim || (!going_fwd && es)) begin
			motor_mode = MODE_IDLE;
			fin = 1'b1;
			return 1'b0;
		end
		steps_to_go = steps_to_go - 1'b1;
		motor_pos = going_fwd ? motor_pos + 1'b1 : motor_pos - 1'b1;
		start_pulse();
		return 1'b1;
	endfunction

	// decision tick of homing: budget, endstop, abort
	function automatic bit home_step(input bit es, input bit ab, output bit fin);
		fin = 1'b0;
		if (steps_to_go == 0) begin
			homed_flag = 1'b0;
			motor_mode = MODE_IDLE;
			fin = 1'b1;
			return 1'b0;
		end
		if (es) begin
			// found it: zero, flag, then back off forward as a plain move
			motor_pos = '0;
			homed_flag = 1'b1;
			motor_mode = MODE_MOVE;
			going_fwd = 1'b1;
			steps_to_go = CNT_W'((int'(backoff_mm_r) * int'(spm_q8)) >>> 8);
			return move_step(es, fin);
		end
		if (ab) begin
			homed_flag = 1'b0;
			motor_mode = MODE_IDLE;
			fin = 1'b1;
			return 1'b0;
		end
		steps_to_go = steps_to_go - 1'b1;
		start_pulse();
		return 1'b1;
	endfunction

	// one request in, one result out
	function automatic result_t advance_motor(input motor_cmd_t c);
		result_t r;
		bit step;
		bit fin;
		bit rej;
		int tq;
		int tgt;
		int delta;
		int mag;
		step = 1'b0;
		fin = 1'b0;
		rej = 1'b0;
		if (c.req != REQ_TICK) begin
			if (motor_mode != MODE_IDLE) begin
				rej = 1'b1;
			end else begin
				low_hold = c.low;
				pulse_high_now = 1'b0;
				phase_ticks = '0;
				case (c.req)
					REQ_REL: begin
						motor_mode = MODE_MOVE;
						going_fwd = c.fwd;
						steps_to_go = c.cnt;
					end
					REQ_ABS: begin
						tq = int'(c.tq4);
						if (tq > 16 * int'(travel_mm))
							tq = 16 * int'(travel_mm);
						tgt = int'((longint'(tq) * longint'(spm_q8) + 2048) >>> 12);
						delta = tgt - int'($signed(motor_pos));
						mag = (delta < 0) ? -delta : delta;
						motor_mode = MODE_MOVE;
						going_fwd = (delta > 0);
						steps_to_go = (mag > int'(STEPS_MAX)) ? STEPS_MAX : CNT_W'(mag);
					end
					default: begin
						motor_mode = MODE_HOME;
						going_fwd = 1'b0;
						steps_to_go = c.cnt;
					end
				endcase
			end
		end else if (motor_mode != MODE_IDLE) begin
			if (pulse_high_now) begin
				step = 1'b1;
				phase_ticks = phase_ticks - 1'b1;
				if (phase_ticks == 0) begin
					pulse_high_now = 1'b0;
					phase_ticks = low_hold;
				end
			end else if (phase_ticks != 0) begin
				phase_ticks = phase_ticks - 1'b1;
			end else if (motor_mode == MODE_MOVE) begin
				step = move_step(c.endstop, fin);
			end else begin
				step = home_step(c.endstop, c.abort_req, fin);
			end
		end
		r.step = step;
		r.dir = going_fwd;
		r.pos = motor_pos;
		r.busy = (motor_mode != MODE_IDLE);
		r.homing_ok = homed_flag;
		r.finished = fin;
		r.rejected = rej;
		return r;
	endfunction

	function automatic motor_cmd_t make_cmd(input req_t r, input int unsigned cnt,
			input bit fwd, input int unsigned tq4, input int unsigned low,
			input bit es, input bit ab);
		motor_cmd_t c;
		c.req = r;
		c.cnt = CNT_W'(cnt);
		c.fwd = fwd;
		c.tq4 = TQ4_W'(tq4);
		c.low = LOWT_W'(low);
		c.endstop = es;
		c.abort_req = ab;
		return c;
	endfunction

	// mostly well-formed traffic: commands when idle, ticks while busy, and some noise
	function automatic motor_cmd_t random_cmd();
		motor_cmd_t c;
		c.req = REQ_TICK;
		c.cnt = CNT_W'($urandom);
		c.fwd = 1'($urandom);
		c.tq4 = TQ4_W'($urandom);
		c.low = LOWT_W'($urandom);
		c.endstop = ($urandom_range(0, (motor_mode == MODE_HOME) ? 5 : 11) == 0);
		c.abort_req = ($urandom_range(0, 19) == 0);
		if (motor_mode == MODE_IDLE) begin
			if ($urandom_range(0, 6) != 0) begin
				c.req = req_t'($urandom_range(1, 3));
				c.low = ($urandom_range(0, 4) == 0) ? LOWT_W'($urandom_range(0, 12))
					: LOWT_W'($urandom_range(0, 3));
				case (c.req)
					REQ_REL: c.cnt = CNT_W'($urandom_range(0, 24));
					REQ_ABS: c.tq4 = TQ4_W'($urandom_range(0, 16 * (int'(travel_mm) + 2)));
					default: c.cnt = CNT_W'($urandom_range(0, 30));
				endcase
			end
		end else if ($urandom_range(0, 12) == 0) begin
			c.req = req_t'($urandom_range(1, 3));   // bounced: block is busy
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Called and returns at a falling edge; the transfer
	// happens at the rising edge with in_valid high and in_stall low.
	// ------------------------------------------------------------------
	task automatic send_item(input motor_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = (!gaps_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid = 1'b1;
		req_type = c.req;
		step_count = c.cnt;
		move_forward = c.fwd;
		target_mm_q4 = c.tq4;
		low_ticks = c.low;
		endstop_pressed = c.endstop;
		monitor_abort = c.abort_req;
		do
			@(posedge clk);
		while (in_stall);
		motor_reports_due.push_back(advance_motor(c));
		burst_left--;
		@(negedge clk);
	endtask

	task automatic tick_n(input int n, input bit es, input bit ab);
		repeat (n) send_item(make_cmd(REQ_TICK, 0, 0, 0, 0, es, ab));
	endtask

	task automatic tick_until_idle(input bit es, input bit ab);
		while (motor_mode != MODE_IDLE)
			send_item(make_cmd(REQ_TICK, 0, 0, 0, 0, es, ab));
	endtask

	task automatic tick_while_mode(input mode_t m, input bit es, input bit ab);
		while (motor_mode == m)
			send_item(make_cmd(REQ_TICK, 0, 0, 0, 0, es, ab));
	endtask

	// stop sending, let every owed result come back, then a short margin
	task automatic wait_quiet();
		in_valid = 1'b0;
		while (motor_reports_due.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_STEPS_PER_MM: spm_q8 = cfg_data;
			CFG_MAX_TRAVEL:   travel_mm = cfg_data[TRAVEL_W-1:0];
			CFG_BACKOFF:      backoff_mm_r = cfg_data[BACKOFF_W-1:0];
			default:          high_ticks = cfg_data[PHIGH_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(input int unsigned spm, input int unsigned travel,
			input int unsigned backoff, input int unsigned phigh);
		wait_quiet();
		write_reg(CFG_STEPS_PER_MM, spm);
		write_reg(CFG_MAX_TRAVEL, travel);
		write_reg(CFG_BACKOFF, backoff);
		write_reg(CFG_PULSE_HIGH, phigh);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset registers: 100 steps/mm, 10-tick pulses
	task automatic test_reset_config_moves();
		tick_n(2, 1'b1, 1'b1);                              // ticks while idle change nothing
		send_item(make_cmd(REQ_REL, 2, 1, 0, 3, 0, 0));
		tick_until_idle(1'b0, 1'b0);
		send_item(make_cmd(REQ_REL, 0, 0, 0, 0, 0, 0));     // zero steps: ends on next tick
		tick_until_idle(1'b0, 1'b0);
		send_item(make_cmd(REQ_ABS, 0, 0, 1, 0, 0, 0));     // 1/16 mm rounds to 6 steps
		send_item(make_cmd(REQ_HOME, '1, 1, '1, '1, 1, 1)); // busy: bounced
		tick_n(5, 1'b0, 1'b0);
		send_item(make_cmd(REQ_REL, 0, 0, 0, 0, 0, 0));     // bounced mid-pulse
		tick_until_idle(1'b0, 1'b0);
		send_item(make_cmd(REQ_ABS, 0, 1, 1, 0, 0, 0));     // already at target
		tick_until_idle(1'b0, 1'b0);
	endtask

	task automatic test_register_extremes();
		// widest scale, travel 1 mm, pulse_high 0 behaves as 1
		set_config(16'hFFFF, 1, 0, 0);
		send_item(make_cmd(REQ_ABS, 0, 0, 0, 1, 0, 0));
		tick_until_idle(1'b0, 1'b0);
		// zero travel: one step out, then the limit stops the move
		set_config(16'hFFFF, 0, 0, 0);
		send_item(make_cmd(REQ_REL, '1, 1, 0, 0, 0, 0));
		tick_until_idle(1'b0, 1'b0);
		send_item(make_cmd(REQ_REL, 0, 0, 0, '1, 0, 0));    // longest low time, never used
		tick_until_idle(1'b0, 1'b0);
		// homing with zero backoff ends on the endstop tick itself
		send_item(make_cmd(REQ_HOME, '1, 0, 0, 0, 0, 0));
		tick_n(3, 1'b0, 1'b0);
		tick_while_mode(MODE_HOME, 1'b1, 1'b0);
		// smallest scale: limit 3 steps, backoff rounds down to nothing
		set_config(1, 1023, 255, 1);
		send_item(make_cmd(REQ_ABS, 0, 0, '1, 0, 0, 0));    // clamped to the travel limit
		tick_until_idle(1'b0, 1'b0);
		set_config(1, 1023, 255, 255);
		send_item(make_cmd(REQ_REL, 1, 0, 0, 2, 0, 0));     // one long pulse backward
		tick_until_idle(1'b0, 1'b0);
	endtask

	task automatic test_homing();
		set_config(256, 20, 3, 2);                          // 1 step/mm, 3-step backoff
		send_item(make_cmd(REQ_HOME, 10, 0, 0, 1, 0, 0));
		tick_n(4, 1'b0, 1'b0);
		tick_while_mode(MODE_HOME, 1'b1, 1'b0);
		tick_until_idle(1'b1, 1'b0);                        // endstop ignored going forward
		send_item(make_cmd(REQ_HOME, 10, 0, 0, 0, 0, 0));
		tick_n(3, 1'b0, 1'b0);
		tick_while_mode(MODE_HOME, 1'b0, 1'b1);             // monitor abort
		send_item(make_cmd(REQ_HOME, 2, 0, 0, 0, 0, 0));
		tick_until_idle(1'b0, 1'b0);                        // budget runs out
		send_item(make_cmd(REQ_HOME, 0, 0, 0, 0, 0, 0));
		tick_until_idle(1'b0, 1'b0);
		send_item(make_cmd(REQ_REL, 10, 0, 0, 0, 0, 0));    // backward move hits endstop
		tick_n(3, 1'b0, 1'b0);
		tick_until_idle(1'b1, 1'b0);
	endtask

	// receiver holds off while ticks keep coming: the block must fill and stall
	task automatic test_backpressure();
		set_config(256, 1023, 2, 1);
		gaps_on = 1'b0;
		send_item(make_cmd(REQ_REL, 40, 1, 0, 0, 0, 0));
		hold_requests++;
		tick_n(80, 1'b0, 1'b0);
		gaps_on = 1'b1;
		tick_until_idle(1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		motor_cmd_t c;
		int worked;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_config($urandom_range(96, 520), $urandom_range(0, 24),
				$urandom_range(0, 8), $urandom_range(0, 3));
			worked = 0;
			while (worked < RANDOM_ITEMS / RANDOM_PHASES) begin
				c = random_cmd();
				// idle ticks and bounced commands do not count
				if (c.req == REQ_TICK ? motor_mode != MODE_IDLE : motor_mode == MODE_IDLE)
					worked++;
				send_item(c);
			end
			tick_until_idle(1'b0, 1'b0);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern driven at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1'b1;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 120);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 9) < 6);
				default: out_stall = (stall_left % 3 == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("cycle %0d: %s expected %0h got %0h", cycles, name, want_v, got_v);
		end
	endtask

	// every result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (motor_reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: result with nothing owed", cycles);
			end else begin
				want = motor_reports_due.pop_front();
				check_field("step_out", want.step, step_out);
				check_field("dir_out", want.dir, dir_out);
				check_field("position_steps", want.pos, $unsigned(position_steps));
				check_field("busy_res", want.busy, busy_res);
				check_field("homing_ok", want.homing_ok, homing_ok);
				check_field("finished", want.finished, finished);
				check_field("cmd_rejected", want.rejected, cmd_rejected);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_config_moves();
		test_register_extremes();
		test_homing();
		test_backpressure();
		test_random_traffic();

		wait_quiet();
		if (mismatches == 0 && motor_reports_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
